### rtl/scc_pkg.sv
`default_nettype none
package scc_pkg;

  // default table size: grains per side
  localparam int MAX_GRAINS_DEF = 64;
  // fraction bits of the unit normal
  localparam int NORM_BITS = 30;
  // stream widths, whole bytes
  localparam int IN_W = 272;
  localparam int OUT_W = 232;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQ,
    ST_CMP,
    ST_SQRT,
    ST_DIV,
    ST_PT,
    ST_RD_AB,
    ST_WR_AB,
    ST_RD_BA,
    ST_WR_BA,
    ST_OUT
  } state_t;

  // saturate a signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7fffffff;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/scc_isqrt.sv
`default_nettype none
module scc_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [66:0] value,
  output logic             done,
  output logic [35:0]      root
);
  logic [71:0] vsh;
  logic [39:0] rem;
  logic [5:0]  cnt;
  logic        run;
  logic [39:0] rem_sh;
  logic [39:0] trial;
  logic        ge;

  // one result bit per cycle, two radicand bits shifted in
  always_comb begin
    rem_sh = {rem[37:0], vsh[71:70]};
    trial  = {2'b00, root, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == 6'd0);
      if (start) run <= 1'b1;
      else if (cnt == 6'd0) run <= 1'b0;
    end
    if (start) begin
      vsh  <= {5'b0, value};
      rem  <= '0;
      root <= '0;
      cnt  <= 6'd35;
    end else if (run) begin
      rem  <= ge ? rem_sh - trial : rem_sh;
      root <= {root[34:0], ge};
      vsh  <= {vsh[69:0], 2'b00};
      cnt  <= cnt - 6'd1;
    end
  end
endmodule
`default_nettype wire

### rtl/scc_div.sv
`default_nettype none
module scc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [32:0] dabs,
  input  wire logic [35:0] den,
  output logic             done,
  output logic [30:0]      quot
);
  import scc_pkg::*;

  logic [63:0] num;
  logic [36:0] rmd;
  logic [30:0] low;
  logic [4:0]  cnt;
  logic        run;
  logic [36:0] rs;
  logic        ge;

  // rounded numerator: |d| scaled to the normal format plus half the divisor
  always_comb begin
    num = (64'(dabs) << NORM_BITS) + 64'(den[35:1]);
    rs  = {rmd[35:0], low[30]};
    ge  = rs >= {1'b0, den};
  end

  // restoring division, quotient known to fit 31 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == 5'd0);
      if (start) run <= 1'b1;
      else if (cnt == 5'd0) run <= 1'b0;
    end
    if (start) begin
      rmd  <= {5'b0, num[62:31]};
      low  <= num[30:0];
      quot <= '0;
      cnt  <= 5'd30;
    end else if (run) begin
      rmd  <= ge ? rs - {1'b0, den} : rs;
      quot <= {quot[29:0], ge};
      low  <= {low[29:0], 1'b0};
      cnt  <= cnt - 5'd1;
    end
  end
endmodule
`default_nettype wire

### rtl/sphere_contact_with_initial_overlap_unit.sv
`default_nettype none
// Sphere-sphere contact unit with a first-overlap table per ordered grain pair.
// Input channel s_*: one request holds both centres, both radii, both grain
// numbers and the keep flag. Output channel m_*: one result per request with
// the contact flag, contact point, unit normal, penetration and mismatch flag.
// A request with contact goes, in order, through the squared distance, a
// compare, the bit-serial square root (36 steps), the three parallel normal
// dividers (31 steps each), the contact point multiplies, the pair table
// read-modify-write and the load of the output register.
// A request without contact skips the root, divide, contact point and table
// and goes straight to the output register.
// One request is worked at a time; s_tready is high only while idle.
// The output register holds a result until m_tready takes it, and a new
// request is accepted meanwhile; the next result waits for it to drain.
// After reset the pair table (MAX_GRAINS*MAX_GRAINS entries, 4096 by default)
// is cleared one entry per cycle, with s_tready low.
module sphere_contact_with_initial_overlap_unit #(
  parameter int MAX_GRAINS = scc_pkg::MAX_GRAINS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, radius_a, radius_b,
  // grain_a, grain_b, keep_contact
  input  wire logic [scc_pkg::IN_W-1:0] s_tdata,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  // in_contact, point_x, point_y, point_z, normal_x, normal_y, normal_z,
  // penetration, depth_mismatch
  output logic [scc_pkg::OUT_W-1:0]    m_tdata
);
  import scc_pkg::*;

  localparam int DEPTH = MAX_GRAINS * MAX_GRAINS;
  localparam int IDXW  = $clog2(DEPTH);

  state_t state, state_next;

  logic signed [31:0] pa [3];
  logic signed [32:0] dd [3];
  logic        [2:0]  dneg;
  logic [30:0]        ra;
  logic [31:0]        rs;
  logic [63:0]        rs2;
  logic [66:0]        dist2;
  logic [5:0]         ga_r, gb_r;
  logic               keep;
  logic [1:0]         k, ph;
  logic [35:0]        len;
  logic signed [37:0] overlap;
  logic [37:0]        s2abs;
  logic               s2neg;
  logic [30:0]        qv [3];
  logic [68:0]        acc;
  logic signed [31:0] ovsat, d1;
  logic [IDXW-1:0]    iab, iba, clr;

  logic               res_contact, res_mis;
  logic signed [31:0] res_point [3];
  logic signed [31:0] res_normal [3];
  logic signed [31:0] res_pen;

  logic [32:0]        mem [DEPTH];
  logic [32:0]        rdata;
  logic               mem_we;
  logic [IDXW-1:0]    mem_waddr, mem_raddr;
  logic [32:0]        mem_wdata;

  logic               contact, sq_start, sq_done, dv_start;
  logic [2:0]         dv_done;
  logic [35:0]        root;
  logic [30:0]        quot [3];
  logic [32:0]        dabs [3];
  logic [32:0]        dk_abs;
  logic [65:0]        sq;
  logic [49:0]        pp_lo, pp_hi;
  logic [37:0]        off;
  logic signed [39:0] psum;
  logic signed [38:0] s2;
  logic signed [37:0] ov_new;
  logic signed [31:0] known_val;
  logic signed [38:0] pen_full;

  // square root of the squared distance
  scc_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (dist2),
    .done  (sq_done),
    .root  (root)
  );

  // one divider per axis for the normal, root held stable while they run
  for (genvar a = 0; a < 3; a++) begin : g_div
    assign dabs[a] = dd[a][32] ? 33'(-dd[a]) : 33'(dd[a]);
    scc_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (dv_start),
      .dabs  (dabs[a]),
      .den   (root),
      .done  (dv_done[a]),
      .quot  (quot[a])
    );
  end

  // shared arithmetic
  always_comb begin
    contact   = ({3'b000, rs2} > dist2) || keep;
    dk_abs    = dabs[k];
    sq        = 66'(dk_abs) * 66'(dk_abs);
    pp_lo     = 50'(s2abs[18:0]) * 50'(qv[k]);
    pp_hi     = 50'(s2abs[37:19]) * 50'(qv[k]);
    off       = 38'((acc + (69'(1) << NORM_BITS)) >> (NORM_BITS + 1));
    psum      = (s2neg ^ dneg[k]) ? 40'(pa[k]) - 40'(off) : 40'(pa[k]) + 40'(off);
    ov_new    = 38'(rs) - 38'(len);
    s2        = 39'({ra, 1'b0}) - 39'(ov_new);
    known_val = rdata[32] ? rdata[31:0] : ovsat;
    pen_full  = 39'(overlap) - 39'(d1);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr == IDXW'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (s_tvalid) state_next = ST_SQ;
      ST_SQ:    if (k == 2'd2) state_next = ST_CMP;
      ST_CMP:   state_next = contact ? ST_SQRT : ST_OUT;
      ST_SQRT:  if (sq_done) state_next = ST_DIV;
      ST_DIV:   if (dv_done[0]) state_next = ST_PT;
      ST_PT:    if (k == 2'd2 && ph == 2'd2) state_next = ST_RD_AB;
      ST_RD_AB: state_next = ST_WR_AB;
      ST_WR_AB: state_next = ST_RD_BA;
      ST_RD_BA: state_next = ST_WR_BA;
      ST_WR_BA: state_next = ST_OUT;
      ST_OUT:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs and table access
  always_comb begin
    s_tready  = (state == ST_IDLE);
    sq_start  = (state == ST_CMP) && contact;
    dv_start  = (state == ST_SQRT) && sq_done;
    mem_raddr = (state == ST_RD_BA) ? iba : iab;
    mem_we    = 1'b0;
    mem_waddr = iab;
    mem_wdata = {1'b1, ovsat};
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr;
        mem_wdata = '0;
      end
      ST_WR_AB: mem_we = !rdata[32];
      ST_WR_BA: begin
        mem_we    = !rdata[32];
        mem_waddr = iba;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // pair table
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr <= clr + IDXW'(1);
      if (state == ST_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        for (int a = 0; a < 3; a++) begin
          pa[a] <= s_tdata[32*a +: 32];
          dd[a] <= 33'(signed'(s_tdata[96+32*a +: 32])) - 33'(signed'(s_tdata[32*a +: 32]));
        end
        ra    <= s_tdata[222:192];
        rs    <= 32'(s_tdata[222:192]) + 32'(s_tdata[253:223]);
        ga_r  <= s_tdata[259:254];
        gb_r  <= s_tdata[265:260];
        keep  <= s_tdata[266];
        dist2 <= '0;
        k     <= 2'd0;
      end
      ST_SQ: begin
        // squared distance, one axis per cycle
        dist2 <= dist2 + 67'(sq);
        dneg[k] <= dd[k][32];
        if (k == 2'd0) rs2 <= 64'(rs) * 64'(rs);
        k <= k + 2'd1;
      end
      ST_CMP: begin
        res_contact <= contact;
        res_mis     <= 1'b0;
        res_pen     <= '0;
        for (int a = 0; a < 3; a++) begin
          res_point[a]  <= '0;
          res_normal[a] <= '0;
        end
      end
      ST_SQRT: begin
        // reduce grain numbers modulo the table side
        if (32'(ga_r) >= 32'(MAX_GRAINS)) ga_r <= ga_r - 6'(MAX_GRAINS);
        if (32'(gb_r) >= 32'(MAX_GRAINS)) gb_r <= gb_r - 6'(MAX_GRAINS);
        if (sq_done) begin
          len     <= root;
          overlap <= 38'(rs) - 38'(root);
        end
      end
      ST_DIV: begin
        if (dv_done[0]) begin
          s2abs <= s2[38] ? 38'(-s2) : 38'(s2);
          s2neg <= s2[38];
          ovsat <= sat32(40'(overlap));
          iab   <= IDXW'(ga_r) * IDXW'(MAX_GRAINS) + IDXW'(gb_r);
          iba   <= IDXW'(gb_r) * IDXW'(MAX_GRAINS) + IDXW'(ga_r);
          k     <= 2'd0;
          ph    <= 2'd0;
          for (int a = 0; a < 3; a++) begin
            logic [30:0] q;
            q = quot[a];
            if (len == '0) q = '0;
            else if (q > (31'(1) << NORM_BITS)) q = 31'(1) << NORM_BITS;
            qv[a] <= q;
            res_normal[a] <= dneg[a] ? -32'(q) : 32'(q);
          end
        end
      end
      ST_PT: begin
        // contact point: two partial products and a rounding step per axis
        case (ph)
          2'd0: begin
            acc <= 69'(pp_lo);
            ph  <= 2'd1;
          end
          2'd1: begin
            acc <= acc + (69'(pp_hi) << 19);
            ph  <= 2'd2;
          end
          default: begin
            res_point[k] <= sat32(psum);
            ph <= 2'd0;
            k  <= k + 2'd1;
          end
        endcase
      end
      ST_WR_AB: d1 <= known_val;
      ST_WR_BA: begin
        res_pen <= sat32(40'(pen_full));
        res_mis <= (d1 != known_val);
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {6'b0, res_mis, res_pen, res_normal[2], res_normal[1],
                      res_normal[0], res_point[2], res_point[1], res_point[0],
                      res_contact};
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### tb/sphere_contact_checker.sv
`timescale 1ns / 1ps
module sphere_contact_checker (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  input  wire logic                     s_tready,
  input  wire logic [scc_pkg::IN_W-1:0]  s_tdata,
  input  wire logic                     m_tvalid,
  input  wire logic                     m_tready,
  input  wire logic [scc_pkg::OUT_W-1:0] m_tdata,
  output int                            errors,
  output int                            pending
);

  localparam int GRAINS = scc_pkg::MAX_GRAINS_DEF;

  // expected contact results, oldest first
  logic [scc_pkg::OUT_W-1:0] contact_q[$];

  // first overlap per ordered grain pair
  logic signed [31:0] first_depth [GRAINS*GRAINS];
  logic               depth_known [GRAINS*GRAINS];

  function automatic logic [63:0] mag64(input longint signed v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [31:0] clamp32(input longint signed v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // geometry and pair table update for one request
  function automatic logic [scc_pkg::OUT_W-1:0] contact_geometry(
      input logic [scc_pkg::IN_W-1:0] req);
    longint signed pa [3];
    longint signed dl [3];
    longint signed nrm [3];
    logic [31:0]   pt [3];
    logic [79:0]   dist2;
    logic [63:0]   ad, rs, len, cand, ra, rb;
    logic [127:0]  sq, mag;
    logic [79:0]   q;
    longint signed overlap, s2, off, d1, d2;
    logic [5:0]    ga, gb;
    int            iab, iba;
    logic          keep;
    dist2 = '0;
    ra = req[222:192];
    rb = req[253:223];
    ga = req[259:254];
    gb = req[265:260];
    keep = req[266];
    rs = ra + rb;
    for (int k = 0; k < 3; k++) begin
      pa[k] = longint'($signed(req[32*k +: 32]));
      dl[k] = longint'($signed(req[96 + 32*k +: 32])) - pa[k];
      ad = mag64(dl[k]);
      dist2 += ad * ad;
    end
    if (!(dist2 < rs * rs || keep)) return '0;
    // floor square root, bit by bit
    len = '0;
    for (int b = 35; b >= 0; b--) begin
      cand = len | (64'd1 << b);
      sq = cand * cand;
      if (sq <= dist2) len = cand;
    end
    overlap = longint'(rs) - longint'(len);
    s2 = 2 * longint'(ra) - overlap;
    for (int k = 0; k < 3; k++) begin
      if (len == 0) begin
        nrm[k] = 0;
      end else begin
        q = ((80'(mag64(dl[k])) << scc_pkg::NORM_BITS) + (len >> 1)) / len;
        if (q > (80'd1 << scc_pkg::NORM_BITS)) q = 80'd1 << scc_pkg::NORM_BITS;
        nrm[k] = dl[k] < 0 ? -longint'(q) : longint'(q);
      end
      mag = 128'(mag64(s2)) * 128'(mag64(nrm[k]));
      off = longint'((mag + (128'd1 << scc_pkg::NORM_BITS)) >> (scc_pkg::NORM_BITS + 1));
      if ((s2 < 0) != (nrm[k] < 0)) off = -off;
      pt[k] = clamp32(pa[k] + off);
    end
    iab = {ga, gb};
    iba = {gb, ga};
    if (!depth_known[iab]) begin
      first_depth[iab] = clamp32(overlap);
      depth_known[iab] = 1'b1;
    end
    if (!depth_known[iba]) begin
      first_depth[iba] = clamp32(overlap);
      depth_known[iba] = 1'b1;
    end
    d1 = first_depth[iab];
    d2 = first_depth[iba];
    return {6'd0, d1 != d2, clamp32(overlap - d1), nrm[2][31:0], nrm[1][31:0],
            nrm[0][31:0], pt[2], pt[1], pt[0], 1'b1};
  endfunction

  task automatic report(input string field, input logic [31:0] want,
                        input logic [31:0] got);
    $display("field %s: expected %h, got %h at %0t", field, want, got, $realtime);
    errors++;
  endtask

  initial begin
    errors = 0;
  end

  assign pending = contact_q.size();

  always @(posedge clk) begin
    logic [scc_pkg::OUT_W-1:0] want;
    if (rst) begin
      contact_q.delete();
      for (int i = 0; i < GRAINS*GRAINS; i++) depth_known[i] = 1'b0;
    end else begin
      // new request: predict its result
      if (s_tvalid && s_tready) contact_q.push_back(contact_geometry(s_tdata));
      // result: compare with the oldest prediction
      if (m_tvalid && m_tready) begin
        if (contact_q.size() == 0) begin
          $display("result with no request waiting at %0t", $realtime);
          errors++;
        end else begin
          want = contact_q.pop_front();
          if (want[0] != m_tdata[0]) report("in_contact", want[0], m_tdata[0]);
          if (want[32:1] != m_tdata[32:1]) report("point_x", want[32:1], m_tdata[32:1]);
          if (want[64:33] != m_tdata[64:33]) report("point_y", want[64:33], m_tdata[64:33]);
          if (want[96:65] != m_tdata[96:65]) report("point_z", want[96:65], m_tdata[96:65]);
          if (want[128:97] != m_tdata[128:97])
            report("normal_x", want[128:97], m_tdata[128:97]);
          if (want[160:129] != m_tdata[160:129])
            report("normal_y", want[160:129], m_tdata[160:129]);
          if (want[192:161] != m_tdata[192:161])
            report("normal_z", want[192:161], m_tdata[192:161]);
          if (want[224:193] != m_tdata[224:193])
            report("penetration", want[224:193], m_tdata[224:193]);
          if (want[225] != m_tdata[225])
            report("depth_mismatch", want[225], m_tdata[225]);
        end
      end
    end
  end

endmodule

### tb/tb_sphere_contact_with_initial_overlap_unit.sv
`timescale 1ns / 1ps
module tb_sphere_contact_with_initial_overlap_unit;

  localparam int RANDOM_REQS = 450;
  localparam int CYCLE_LIMIT = 600000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [scc_pkg::IN_W-1:0]  s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [scc_pkg::OUT_W-1:0] m_tdata;
  int                        errors;
  int                        pending;
  int                        cycles = 0;
  int                        sent = 0;
  logic                      hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sphere_contact_with_initial_overlap_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  sphere_contact_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  // fields: pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
  // radius_a, radius_b, grain_a, grain_b, keep_contact
  function automatic logic [scc_pkg::IN_W-1:0] pack_req(
      input logic [31:0] ax, ay, az, bx, by, bz,
      input logic [30:0] ra, rb, input logic [5:0] ga, gb, input logic keep);
    return {5'd0, keep, gb, ga, rb, ra, bz, by, bx, az, ay, ax};
  endfunction

  // request on the input channel; burst gaps handled by the caller
  task automatic send(input logic [scc_pkg::IN_W-1:0] req);
    s_tdata <= req;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // mostly touching spheres on a few grains, some pure noise
  function automatic logic [scc_pkg::IN_W-1:0] random_req();
    logic [31:0] a [3];
    logic [31:0] b [3];
    logic [30:0] ra, rb;
    int          span;
    if ($urandom_range(0, 7) == 0)
      return pack_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 9) == 0) begin
      ra = $urandom;
      rb = $urandom;
    end else begin
      ra = $urandom_range(1, 1 << 21);
      rb = $urandom_range(1, 1 << 21);
    end
    span = ra + rb > 31'h3fffffff ? 32'h3fffffff : int'(ra + rb);
    for (int k = 0; k < 3; k++) begin
      a[k] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 24) - (1 << 23);
      b[k] = a[k] + $urandom_range(0, span) - span / 2;
    end
    return pack_req(a[0], a[1], a[2], b[0], b[1], b[2], ra, rb,
                    $urandom_range(0, 5) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 5),
                    $urandom_range(0, 5) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 5),
                    $urandom_range(0, 7) == 0);
  endfunction

  // stimulus: directed corners, then random bursts
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // coincident centres, then same grain twice
    send(pack_req(0, 0, 0, 0, 0, 0, 31'h10000, 31'h10000, 1, 2, 0));
    send(pack_req(5, 5, 5, 5, 5, 5, 31'h10000, 31'h8000, 3, 3, 0));
    // reversed pair after first contact, different overlap
    send(pack_req(0, 0, 0, 32'h18000, 0, 0, 31'h10000, 31'h10000, 2, 1, 0));
    send(pack_req(0, 0, 0, 32'h10000, 0, 0, 31'h10000, 31'h10000, 1, 2, 0));
    // no contact, and the same kept by the flag
    send(pack_req(0, 0, 0, 32'h100000, 0, 0, 31'h10, 31'h10, 4, 5, 0));
    send(pack_req(0, 0, 0, 32'h100000, 0, 0, 31'h10, 31'h10, 4, 5, 1));
    // extreme coordinates and radii
    send(pack_req(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                  32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff, 63, 0, 0));
    send(pack_req(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                  32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff, 0, 63, 1));
    send(pack_req(32'h7fffffff, 0, 0, 32'h7ffffff0, 0, 0, 31'h7fffffff, 0, 63, 63, 0));
    send(pack_req(32'h80000000, 0, 0, 32'h80000010, 0, 0, 31'h7fffffff, 31'h7fffffff,
                  10, 11, 0));
    send(pack_req(0, 32'hffff0000, 0, 0, 0, 32'h10000, 0, 0, 12, 13, 1));
    send(pack_req(0, 0, 32'h10000, 0, 0, 32'hffff0000, 31'h20000, 0, 13, 12, 0));
    send(pack_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  0, 0, 14, 15, 0));
    for (int i = 0; i < RANDOM_REQS;) begin
      for (int n = $urandom_range(1, 12); n > 0 && i < RANDOM_REQS; n--, i++)
        send(random_req());
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 120)) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("sphere_contact_with_initial_overlap_unit: match");
    else $display("sphere_contact_with_initial_overlap_unit: mismatch");
    $finish;
  end

  // one long receiver hold-off while requests keep coming
  initial begin
    while (sent < 60) @(posedge clk);
    hold_off = 1'b1;
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
  end

  // receiver stall pattern, changing mode now and then
  always @(posedge clk) begin
    int mode;
    mode = (cycles / 500) % 4;
    if (hold_off) m_tready <= 1'b0;
    else if (mode == 0) m_tready <= 1'b1;
    else if (mode == 1) m_tready <= $urandom_range(0, 1);
    else if (mode == 2) m_tready <= $urandom_range(0, 7) == 0;
    else m_tready <= $urandom_range(0, 15) > 2;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sphere_contact_with_initial_overlap_unit: mismatch");
      $finish;
    end
  end

endmodule

### files.f
rtl/scc_pkg.sv
rtl/scc_isqrt.sv
rtl/scc_div.sv
rtl/sphere_contact_with_initial_overlap_unit.sv
tb/sphere_contact_checker.sv
tb/tb_sphere_contact_with_initial_overlap_unit.sv
